@@ rtl/core/mlps_pkg.sv @@
// Package: shared sizes, command and status words, controller states.
`timescale 1ns / 1ps
`default_nettype none
package mlps_pkg;

  localparam int MAX_ELEMS = 1024;
  localparam int ELEM_BITS = 32;
  localparam int SUM_W     = 42;
  localparam int PARTS_W   = 11;
  localparam int CNT_W     = $clog2(MAX_ELEMS + 1);
  localparam int ADDR_W    = $clog2(MAX_ELEMS);

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CHECK,
    S_SETUP,
    S_PROBE,
    S_EVAL,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic init;
    logic probe_start;
    logic probe_run;
    logic eval;
    logic finish;
  } mlps_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic search_done;
    logic walk_done;
  } mlps_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/mlps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mlps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/mlps_datapath.sv @@
// Datapath: element store, sums, search bounds and greedy probe walk.
`timescale 1ns / 1ps
`default_nettype none
module mlps_datapath
  import mlps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mlps_cmd_t            cmd,
  output mlps_stat_t                stat,
  input  wire logic [ELEM_BITS-1:0] element_value,
  input  wire logic                 cfg_we,
  input  wire logic [PARTS_W-1:0]   cfg_wdata,
  output logic      [SUM_W-1:0]     best_max_sum
);

  logic [PARTS_W-1:0]   max_parts;
  logic [CNT_W-1:0]     element_count;
  logic [SUM_W-1:0]     total_sum;
  logic [SUM_W-1:0]     search_low;
  logic [SUM_W-1:0]     search_high;
  logic [SUM_W-1:0]     mid;
  logic [SUM_W-1:0]     run_sum;
  logic [CNT_W-1:0]     run_count;
  logic                 fail;
  logic [CNT_W-1:0]     rd_idx;
  logic                 rd_valid;
  logic [ELEM_BITS-1:0] rd_data;

  logic                 store_we;
  logic [PARTS_W-1:0]   parts_eff;
  logic [SUM_W:0]       mid_sum;
  logic [SUM_W:0]       run_sum_add;
  logic                 run_over;
  logic [SUM_W-1:0]     run_sum_next;
  logic [CNT_W-1:0]     run_count_next;
  logic                 fail_next;
  logic                 rd_issue;
  logic                 probe_pass;

  assign store_we = cmd.load && (element_count < CNT_W'(MAX_ELEMS));

  mlps_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (MAX_ELEMS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (element_count[ADDR_W-1:0]),
    .wdata (element_value),
    .raddr (rd_idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Treat a zero part limit as one
  assign parts_eff = (max_parts == '0) ? PARTS_W'(1) : max_parts;

  // Sum of the current bounds; its upper bits give the midpoint at probe start
  assign mid_sum = {1'b0, search_low} + {1'b0, search_high};

  // One greedy step on the word read back from the store
  always_comb begin
    run_sum_add    = {1'b0, run_sum} + (SUM_W + 1)'(rd_data);
    run_over       = run_sum_add > {1'b0, mid};
    run_sum_next   = run_over ? SUM_W'(rd_data) : run_sum_add[SUM_W-1:0];
    run_count_next = run_over ? run_count + CNT_W'(1) : run_count;
    fail_next      = fail || (SUM_W'(rd_data) > mid) ||
                     ((PARTS_W > CNT_W ? PARTS_W : CNT_W)'(run_count_next) >
                      (PARTS_W > CNT_W ? PARTS_W : CNT_W)'(parts_eff));
  end

  assign rd_issue   = cmd.probe_run && (rd_idx < element_count);
  assign probe_pass = !fail &&
                      ((PARTS_W > CNT_W ? PARTS_W : CNT_W)'(run_count) <
                       (PARTS_W > CNT_W ? PARTS_W : CNT_W)'(parts_eff));

  // Hold the part limit
  always_ff @(posedge clk) begin
    if (rst) begin
      max_parts <= PARTS_W'(1);
    end else if (cfg_we) begin
      max_parts <= cfg_wdata;
    end
  end

  // Load, search bounds and probe walk
  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      total_sum     <= '0;
      search_low    <= '0;
      search_high   <= '0;
      mid           <= '0;
      run_sum       <= '0;
      run_count     <= '0;
      fail          <= 1'b0;
      rd_idx        <= '0;
      rd_valid      <= 1'b0;
    end else begin
      if (store_we) begin
        element_count <= element_count + CNT_W'(1);
        total_sum     <= total_sum + SUM_W'(element_value);
      end
      if (cmd.init) begin
        search_low  <= '0;
        search_high <= total_sum;
      end
      if (cmd.probe_start) begin
        mid       <= mid_sum[SUM_W:1];
        run_sum   <= '0;
        run_count <= '0;
        fail      <= 1'b0;
        rd_idx    <= '0;
        rd_valid  <= 1'b0;
      end else begin
        if (rd_issue) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
        rd_valid <= rd_issue;
        if (rd_valid) begin
          run_sum   <= run_sum_next;
          run_count <= run_count_next;
          fail      <= fail_next;
        end
      end
      if (cmd.eval) begin
        if (probe_pass) begin
          search_high <= mid;
        end else begin
          search_low <= mid + SUM_W'(1);
        end
      end
      if (cmd.finish) begin
        element_count <= '0;
        total_sum     <= '0;
      end
    end
  end

  assign stat = '{search_done: !(search_low < search_high),
                  walk_done:   (rd_idx == element_count) && !rd_valid};
  assign best_max_sum = search_low;

`ifndef SYNTHESIS
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    search_low <= search_high)
    else $error("search bounds crossed");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(MAX_ELEMS))
    else $error("element count beyond store depth");

  a_finish_converged: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> search_low == search_high)
    else $error("result given before search converged");
`endif

endmodule
`default_nettype wire

@@ rtl/core/mlps_ctrl.sv @@
// Controller: sequences load, binary search probes and the result strobe.
`timescale 1ns / 1ps
`default_nettype none
module mlps_ctrl
  import mlps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       is_last,
  input  wire mlps_stat_t stat,
  output mlps_cmd_t       cmd,
  output logic            busy,
  output logic            done
);

  state_t state;
  state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && is_last) state_next = S_INIT;
      end
      S_INIT:  state_next = S_CHECK;
      S_CHECK: state_next = stat.search_done ? S_DONE : S_SETUP;
      S_SETUP: state_next = S_PROBE;
      S_PROBE: begin
        if (stat.walk_done) state_next = S_EVAL;
      end
      S_EVAL:  state_next = S_CHECK;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_INIT:  cmd.init = 1'b1;
      S_CHECK: ;
      S_SETUP: cmd.probe_start = 1'b1;
      S_PROBE: cmd.probe_run = 1'b1;
      S_EVAL:  cmd.eval = 1'b1;
      S_DONE: begin
        cmd.finish = 1'b1;
        done       = 1'b1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/min_largest_partition_sum_top.sv @@
// Top level: smallest largest-run sum over a loaded sequence.
// Words load one per cycle while idle; a word without the last flag gives no result.
// After the last word the controller runs P probes before the done strobe,
// P the probe count (at most 42, one per bit of the total sum); each probe
// walks the N held words through the single read port of the element store.
// Synchronous active-high reset: idle, count and sums cleared, max_parts = 1;
// the element store is not cleared. The receiver cannot stall the result.
`timescale 1ns / 1ps
`default_nettype none
module min_largest_partition_sum_top
  import mlps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ELEM_BITS-1:0] element_value,
  input  wire logic                 is_last,
  input  wire logic                 cfg_we,
  input  wire logic [PARTS_W-1:0]   cfg_wdata,
  output logic                      done,
  output logic      [SUM_W-1:0]     best_max_sum
);

  mlps_cmd_t  cmd;
  mlps_stat_t stat;

  mlps_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .is_last (is_last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  mlps_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .element_value (element_value),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .best_max_sum  (best_max_sum)
  );

endmodule
`default_nettype wire

@@ dv/tb_min_largest_partition_sum_top.sv @@
// Testbench for min_largest_partition_sum_top: directed and random sequences.
`timescale 1ns / 1ps
module tb_min_largest_partition_sum_top
  import mlps_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned MAX_GAP     = 40;
  localparam int unsigned SHOW_ERRORS = 10;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 start         = 1'b0;
  logic [ELEM_BITS-1:0] element_value = '0;
  logic                 is_last       = 1'b0;
  logic                 cfg_we        = 1'b0;
  logic [PARTS_W-1:0]   cfg_wdata     = '0;
  logic                 busy;
  logic                 done;
  logic [SUM_W-1:0]     best_max_sum;

  // Predictor state: words held for the open sequence and the run limit
  logic [ELEM_BITS-1:0] held_words[$];
  logic [PARTS_W-1:0]   parts_reg = PARTS_W'(1);
  logic [SUM_W-1:0]     best_sum_q[$];

  int unsigned idle_pct    = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  min_largest_partition_sum_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .element_value (element_value),
    .is_last       (is_last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .best_max_sum  (best_max_sum)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Greedy split: true if the held words fit in at most parts runs of sum <= bound
  function automatic bit fits_in_runs(input logic [63:0] bound, input int unsigned parts);
    logic [63:0] acc;
    int unsigned runs;
    acc  = '0;
    runs = 0;
    foreach (held_words[i]) begin
      if (64'(held_words[i]) > bound) return 1'b0;
      acc = acc + 64'(held_words[i]);
      if (acc > bound) begin
        runs++;
        acc = 64'(held_words[i]);
      end
      if (runs > parts) return 1'b0;
    end
    return (runs + 1) <= parts;
  endfunction

  // Binary search for the smallest bound that the greedy split accepts
  function automatic logic [SUM_W-1:0] smallest_bound();
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    int unsigned parts;
    parts = (parts_reg == 0) ? 1 : int'(parts_reg);
    lo = '0;
    hi = '0;
    foreach (held_words[i]) hi = hi + 64'(held_words[i]);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (fits_in_runs(mid, parts)) hi = mid;
      else lo = mid + 1;
    end
    return lo[SUM_W-1:0];
  endfunction

  // Mixed element values: small, mid, full range, extremes, top bit set
  function automatic logic [ELEM_BITS-1:0] random_value();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return ELEM_BITS'($urandom_range(15));
    if (pick < 55) return ELEM_BITS'($urandom_range(1000));
    if (pick < 85) return ELEM_BITS'($urandom);
    if (pick < 95) return ($urandom_range(1) != 0) ? '1 : '0;
    return ELEM_BITS'($urandom) | (ELEM_BITS'(1) << (ELEM_BITS - 1));
  endfunction

  task automatic note_error(input string what, input logic [SUM_W-1:0] want,
                            input logic [SUM_W-1:0] got);
    error_count++;
    if (error_count <= SHOW_ERRORS)
      $display("%0t: %s: best_max_sum expected %0d got %0d", $time, what, want, got);
  endtask

  // Send one word; start stays high afterward so back-to-back words need no extra edge
  task automatic send_word(input logic [ELEM_BITS-1:0] value, input bit last);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      element_value <= ELEM_BITS'($urandom);
      is_last <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    element_value <= value;
    is_last       <= last;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    // Word taken: store it unless the store is full, predict on the last flag
    if (held_words.size() < MAX_ELEMS) held_words = {held_words, value};
    if (last) begin
      best_sum_q = {best_sum_q, smallest_bound()};
      held_words.delete();
    end
  endtask

  // Drop start, drain results, then write the run limit while idle
  task automatic write_max_parts(input logic [PARTS_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (best_sum_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_wdata <= PARTS_W'($urandom);
    parts_reg = value;
  endtask

  // Single words at the value extremes, with the reset run limit
  task automatic test_single_words();
    send_word('0, 1'b1);
    send_word('1, 1'b1);
    send_word(1, 1'b1);
  endtask

  // Run limits: small, zero (taken as one), all ones, and wide
  task automatic test_run_limits();
    write_max_parts(PARTS_W'(2));
    send_word(10, 1'b0);
    send_word(20, 1'b0);
    send_word(30, 1'b0);
    send_word(40, 1'b1);
    write_max_parts('0);
    send_word(7, 1'b0);
    send_word(3, 1'b0);
    send_word(9, 1'b1);
    write_max_parts('1);
    send_word('1, 1'b0);
    send_word('0, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(1, 1'b1);
    write_max_parts(PARTS_W'(3));
    repeat (6) send_word(1, 1'b0);
    send_word(1, 1'b1);
    write_max_parts(PARTS_W'(1024));
    send_word('0, 1'b0);
    send_word('0, 1'b1);
  endtask

  // Overfill the store: words past the last entry are dropped, the flag still counts
  task automatic test_store_full();
    write_max_parts(PARTS_W'($urandom_range(2, 40)));
    for (int k = 0; k < MAX_ELEMS; k++) send_word(random_value(), 1'b0);
    repeat (5) send_word('1, 1'b0);
    send_word('1, 1'b1);
  endtask

  // Random sequences over several run limits and idling phases
  task automatic test_random();
    int unsigned phase_sent;
    int unsigned len;
    logic [PARTS_W-1:0] limit;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: limit = PARTS_W'(1);
        1: limit = PARTS_W'(2);
        2: limit = PARTS_W'(3);
        3: limit = '0;
        4: limit = PARTS_W'(1024);
        5: limit = '1;
        6: limit = PARTS_W'($urandom_range(1, 16));
        default: limit = PARTS_W'($urandom_range(1, 2047));
      endcase
      write_max_parts(limit);
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 87 : 10;
      phase_sent = 0;
      while (phase_sent < 16) begin
        case ($urandom_range(19))
          0:       len = $urandom_range(41, 120);
          1, 2, 3, 4, 5: len = $urandom_range(9, 40);
          default: len = $urandom_range(1, 8);
        endcase
        for (int k = 0; k < len; k++) send_word(random_value(), k == len - 1);
        phase_sent += len;
      end
    end
    idle_pct = 0;
  endtask

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (best_sum_q.size() == 0) begin
        note_error("unexpected result", '0, best_max_sum);
      end else begin
        if (best_max_sum !== best_sum_q[0])
          note_error("mismatch", best_sum_q[0], best_max_sum);
        void'(best_sum_q.pop_front());
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_min_largest_partition_sum_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_words();
    test_run_limits();
    test_store_full();
    test_random();
    // Drain outstanding results, then allow a short tail
    start <= 1'b0;
    @(posedge clk);
    while (best_sum_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0)
      $display("tb_min_largest_partition_sum_top: done, clean");
    else
      $display("tb_min_largest_partition_sum_top: done, errors");
    $finish;
  end

endmodule
